// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, sampled on clk, off during rst_n low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// invariant checked at every rising clock edge
`define ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("invariant violated");

// same-cycle implication
`define ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication violated");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

// ===== rtl/core/oaids_pkg.sv =====
// ----------------------------------------------------------------------------
// oaids_pkg
// types and constants for the ordered array with insert, delete and search
// ----------------------------------------------------------------------------
package oaids_pkg;

    localparam int DATA_W    = 32;
    localparam int POS_W     = 7;
    localparam int KIND_W    = 3;
    localparam int STATUS_W  = 2;
    localparam int FIDX_W    = 6;
    localparam int ECNT_W    = 7;
    localparam int DEPTH_DEF = 64;

    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_APPEND = 3'd1;
    localparam logic [KIND_W-1:0] KIND_INSERT = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DELETE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 3'd4;
    localparam logic [KIND_W-1:0] KIND_READ   = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_POS   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [FIDX_W-1:0]        found_index;
        logic signed [DATA_W-1:0] read_value;
        logic [ECNT_W-1:0]        element_count;
    } rsp_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_APPEND = 2'd1,
        CELL_INSERT = 2'd2,
        CELL_DELETE = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     scan_en;
        logic     scan_search;
        logic     scan_read;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

endpackage

// ===== rtl/core/ordered_array_insert_delete_search.sv =====
// clear, append, insert, delete, rejected requests and empty-list searches: result
//   strobed in the cycle after accept; the next request may follow in the very next cycle
// search and read: the result waits for the hit record walking the cell row
//   one cell per cycle toward cell zero; busy stays high for the whole scan
// reset empties the array; the receiver cannot stall the result strobe
// ----------------------------------------------------------------------------
// ordered_array_insert_delete_search
// packed signed array list held in a row of cells, with shift-based insert
// and delete and a chained lowest-index search
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ordered_array_insert_delete_search #(
    parameter int DEPTH = oaids_pkg::DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  oaids_pkg::req_t   req,
    output logic              done,
    output oaids_pkg::rsp_t   rsp
);
    import oaids_pkg::*;

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int IW   = $clog2(DEPTH);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     scan_cnt_reg, scan_cnt_next;
    logic              done_reg, done_next;
    rsp_t              rsp_reg, rsp_next;
    logic [KIND_W-1:0] op_kind_reg;
    logic [POS_W-1:0]  op_pos_reg;
    logic [DATA_W-1:0] op_value_reg;
    logic              latch_op;
    logic              accept;
    logic [CMPW-1:0]   pos_c;
    logic [CMPW-1:0]   cnt_c;
    cell_ctrl_t        cell_ctrl;
    logic [POS_W-1:0]  pos_bus;
    logic [DATA_W-1:0] value_bus;

    logic [DATA_W-1:0] entry_w    [DEPTH];
    logic              hit_w      [DEPTH+1];
    logic [IW-1:0]     hit_idx_w  [DEPTH+1];
    logic [DATA_W-1:0] hit_data_w [DEPTH+1];

    assign busy   = (state_reg == ST_SCAN);
    assign accept = start && !busy;
    assign pos_c  = CMPW'(req.position);
    assign cnt_c  = CMPW'(count_reg);

    assign pos_bus   = busy ? op_pos_reg : req.position;
    assign value_bus = busy ? op_value_reg : req.value;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        scan_cnt_next = scan_cnt_reg;
        done_next     = 1'b0;
        latch_op      = 1'b0;
        rsp_next      = '0;
        cell_ctrl     = '{op: CELL_HOLD, scan_en: 1'b0, scan_search: 1'b0, scan_read: 1'b0};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    done_next = 1'b1;
                    case (req.kind)
                        KIND_CLEAR:
                        begin
                            count_next = '0;
                        end
                        KIND_APPEND:
                        begin
                            if (count_reg == FULL_CNT)
                                rsp_next.status = STATUS_FULL;
                            else
                            begin
                                cell_ctrl.op = CELL_APPEND;
                                count_next   = count_reg + 1'b1;
                            end
                        end
                        KIND_INSERT:
                        begin
                            if (pos_c > cnt_c)
                                rsp_next.status = STATUS_BAD_POS;
                            else if (count_reg == FULL_CNT)
                                rsp_next.status = STATUS_FULL;
                            else
                            begin
                                cell_ctrl.op = CELL_INSERT;
                                count_next   = count_reg + 1'b1;
                            end
                        end
                        KIND_DELETE:
                        begin
                            if (pos_c >= cnt_c)
                                rsp_next.status = STATUS_BAD_POS;
                            else
                            begin
                                cell_ctrl.op = CELL_DELETE;
                                count_next   = count_reg - 1'b1;
                            end
                        end
                        KIND_SEARCH:
                        begin
                            if (count_reg == '0)
                                rsp_next.status = STATUS_NOT_FOUND;
                            else
                            begin
                                done_next     = 1'b0;
                                latch_op      = 1'b1;
                                scan_cnt_next = '0;
                                state_next    = ST_SCAN;
                            end
                        end
                        KIND_READ:
                        begin
                            if (pos_c >= cnt_c)
                                rsp_next.status = STATUS_BAD_POS;
                            else
                            begin
                                done_next     = 1'b0;
                                latch_op      = 1'b1;
                                scan_cnt_next = '0;
                                state_next    = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            rsp_next.status = STATUS_OK;
                        end
                    endcase
                    rsp_next.element_count = ECNT_W'(CMPW'(count_next));
                end
            end
            ST_SCAN:
            begin
                cell_ctrl.scan_en     = 1'b1;
                cell_ctrl.scan_search = (op_kind_reg == KIND_SEARCH);
                cell_ctrl.scan_read   = (op_kind_reg == KIND_READ);
                scan_cnt_next         = scan_cnt_reg + 1'b1;
                if (scan_cnt_reg == FULL_CNT)
                begin
                    done_next              = 1'b1;
                    state_next             = ST_IDLE;
                    rsp_next.element_count = ECNT_W'(CMPW'(count_reg));
                    if (op_kind_reg == KIND_SEARCH)
                    begin
                        if (hit_w[0])
                        begin
                            rsp_next.status      = STATUS_OK;
                            rsp_next.found_index = FIDX_W'(CMPW'(hit_idx_w[0]));
                        end
                        else
                            rsp_next.status = STATUS_NOT_FOUND;
                    end
                    else
                    begin
                        rsp_next.status     = STATUS_OK;
                        rsp_next.read_value = $signed(hit_data_w[0]);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            scan_cnt_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            scan_cnt_reg <= scan_cnt_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (latch_op)
        begin
            op_kind_reg  <= req.kind;
            op_pos_reg   <= req.position;
            op_value_reg <= req.value;
        end
    end

    assign hit_w[DEPTH]      = 1'b0;
    assign hit_idx_w[DEPTH]  = '0;
    assign hit_data_w[DEPTH] = '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_W-1:0] left_data;
        logic [DATA_W-1:0] right_data;

        if (i == 0)
        begin : g_first
            assign left_data = '0;
        end
        else
        begin : g_mid_l
            assign left_data = entry_w[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_data = '0;
        end
        else
        begin : g_mid_r
            assign right_data = entry_w[i+1];
        end

        oaids_cell #(
            .DEPTH (DEPTH),
            .INDEX (i),
            .CW    (CW),
            .IW    (IW)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (cell_ctrl),
            .pos        (pos_bus),
            .count      (count_reg),
            .value      (value_bus),
            .left_data  (left_data),
            .right_data (right_data),
            .entry      (entry_w[i]),
            .up_hit     (hit_w[i+1]),
            .up_idx     (hit_idx_w[i+1]),
            .up_data    (hit_data_w[i+1]),
            .hit        (hit_w[i]),
            .hit_idx    (hit_idx_w[i]),
            .hit_data   (hit_data_w[i])
        );
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    `ASSERT_ALWAYS(a_count_bound, count_reg <= FULL_CNT)
    `ASSERT_IMPLY(a_done_not_busy, done, !busy)
    `ASSERT_NEXT(a_accept_answered, accept, done || busy)
    `ASSERT_IMPLY(a_scan_bound, busy, scan_cnt_reg <= FULL_CNT)
    `ASSERT_IMPLY(a_miss_clean, done && (rsp.status != STATUS_OK),
                  (rsp.found_index == '0) && (rsp.read_value == '0))

endmodule

// ===== rtl/core/oaids_cell.sv =====
// ----------------------------------------------------------------------------
// oaids_cell
// one array entry: shifts with its neighbors on insert and delete, and
// forwards the lowest matching entry (search) or the addressed entry (read) toward cell zero during a scan
// ----------------------------------------------------------------------------
module oaids_cell #(
    parameter int DEPTH = oaids_pkg::DEPTH_DEF,
    parameter int INDEX = 0,
    parameter int CW    = $clog2(oaids_pkg::DEPTH_DEF + 1),
    parameter int IW    = $clog2(oaids_pkg::DEPTH_DEF)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  oaids_pkg::cell_ctrl_t          ctrl,
    input  logic [oaids_pkg::POS_W-1:0]    pos,
    input  logic [CW-1:0]                  count,
    input  logic [oaids_pkg::DATA_W-1:0]   value,
    input  logic [oaids_pkg::DATA_W-1:0]   left_data,
    input  logic [oaids_pkg::DATA_W-1:0]   right_data,
    output logic [oaids_pkg::DATA_W-1:0]   entry,
    input  logic                           up_hit,
    input  logic [IW-1:0]                  up_idx,
    input  logic [oaids_pkg::DATA_W-1:0]   up_data,
    output logic                           hit,
    output logic [IW-1:0]                  hit_idx,
    output logic [oaids_pkg::DATA_W-1:0]   hit_data
);
    import oaids_pkg::*;

    localparam int CMPW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CMPW-1:0] IDX = CMPW'(INDEX);

    logic [DATA_W-1:0] entry_reg;
    logic [DATA_W-1:0] entry_next;
    logic              hit_reg;
    logic [IW-1:0]     hit_idx_reg;
    logic [DATA_W-1:0] hit_data_reg;
    logic [CMPW-1:0]   pos_c;
    logic [CMPW-1:0]   cnt_c;
    logic              own_hit;

    assign pos_c = CMPW'(pos);
    assign cnt_c = CMPW'(count);

    always_comb
    begin
        entry_next = entry_reg;
        unique case (ctrl.op)
            CELL_APPEND:
            begin
                if (IDX == cnt_c)
                    entry_next = value;
            end
            CELL_INSERT:
            begin
                if (IDX > pos_c)
                    entry_next = left_data;
                else if (IDX == pos_c)
                    entry_next = value;
            end
            CELL_DELETE:
            begin
                if (IDX >= pos_c)
                    entry_next = right_data;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    assign own_hit = (ctrl.scan_search && (IDX < cnt_c) && (entry_reg == value))
                  || (ctrl.scan_read && (IDX == pos_c));

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hit_reg <= 1'b0;
        else if (ctrl.scan_en)
            hit_reg <= own_hit || up_hit;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.scan_en)
        begin
            hit_idx_reg  <= own_hit ? IW'(INDEX) : up_idx;
            hit_data_reg <= own_hit ? entry_reg : up_data;
        end
    end

    assign entry    = entry_reg;
    assign hit      = hit_reg;
    assign hit_idx  = hit_idx_reg;
    assign hit_data = hit_data_reg;

endmodule

// ===== test/tb_ordered_array_insert_delete_search.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ordered_array_insert_delete_search
// Drives requests into the packed array list through the start/busy
// handshake. A shadow copy of the list predicts every response, and each
// done strobe is checked field by field against the oldest prediction.
// Directed tests cover the empty list, the edit operations, value extremes
// and the full list. A random mix follows, with bursty request timing.
// ----------------------------------------------------------------------------
module tb_ordered_array_insert_delete_search;

    import oaids_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = DEPTH + 4;

    localparam logic [KIND_W-1:0] KIND_UNUSED_A = 3'd6;
    localparam logic [KIND_W-1:0] KIND_UNUSED_B = 3'd7;

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    req_t  req;
    logic  done;
    rsp_t  rsp;

    logic signed [DATA_W-1:0] shadow_row [DEPTH];
    int                       shadow_len;
    rsp_t                     expected_rsp [$];
    int                       mismatches = 0;
    int                       cycles = 0;
    int                       burst_left;

    ordered_array_insert_delete_search #(
        .DEPTH (DEPTH)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL ordered_array_insert_delete_search");
            $finish;
        end
    end

    // shadow list update and response prediction
    function automatic rsp_t apply_request(input req_t r);
        rsp_t o;
        int   pos;
        bit   hit;
        o   = '0;
        pos = int'(r.position);
        hit = 1'b0;
        case (r.kind)
            KIND_CLEAR:
            begin
                shadow_len = 0;
            end
            KIND_APPEND:
            begin
                if (shadow_len >= DEPTH)
                    o.status = STATUS_FULL;
                else
                begin
                    shadow_row[shadow_len] = r.value;
                    shadow_len++;
                end
            end
            KIND_INSERT:
            begin
                if (pos > shadow_len)
                    o.status = STATUS_BAD_POS;
                else if (shadow_len >= DEPTH)
                    o.status = STATUS_FULL;
                else
                begin
                    for (int i = shadow_len; i > pos; i--)
                        shadow_row[i] = shadow_row[i-1];
                    shadow_row[pos] = r.value;
                    shadow_len++;
                end
            end
            KIND_DELETE:
            begin
                if (pos >= shadow_len)
                    o.status = STATUS_BAD_POS;
                else
                begin
                    for (int i = pos; i + 1 < shadow_len; i++)
                        shadow_row[i] = shadow_row[i+1];
                    shadow_len--;
                end
            end
            KIND_SEARCH:
            begin
                o.status = STATUS_NOT_FOUND;
                for (int i = 0; i < shadow_len; i++)
                begin
                    if (!hit && shadow_row[i] === r.value)
                    begin
                        hit           = 1'b1;
                        o.status      = STATUS_OK;
                        o.found_index = i[FIDX_W-1:0];
                    end
                end
            end
            KIND_READ:
            begin
                if (pos >= shadow_len)
                    o.status = STATUS_BAD_POS;
                else
                    o.read_value = shadow_row[pos];
            end
            default:
            begin
            end
        endcase
        o.element_count = shadow_len[ECNT_W-1:0];
        return o;
    endfunction

    // response checker, one strobe per request
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && done)
        begin
            if (expected_rsp.size() == 0)
            begin
                mismatches++;
                $display("%0t unexpected response: expected none, got %p", $time, rsp);
            end
            else
            begin
                want = expected_rsp.pop_front();
                if (rsp.status !== want.status)
                begin
                    mismatches++;
                    $display("%0t status: expected %0d, got %0d",
                             $time, want.status, rsp.status);
                end
                if (rsp.found_index !== want.found_index)
                begin
                    mismatches++;
                    $display("%0t found_index: expected %0d, got %0d",
                             $time, want.found_index, rsp.found_index);
                end
                if (rsp.read_value !== want.read_value)
                begin
                    mismatches++;
                    $display("%0t read_value: expected %0d, got %0d",
                             $time, want.read_value, rsp.read_value);
                end
                if (rsp.element_count !== want.element_count)
                begin
                    mismatches++;
                    $display("%0t element_count: expected %0d, got %0d",
                             $time, want.element_count, rsp.element_count);
                end
            end
        end
    end

    function automatic req_t make_req(input logic [KIND_W-1:0] k, input int p,
                                      input logic [DATA_W-1:0] v);
        req_t r;
        r.kind     = k;
        r.position = p[POS_W-1:0];
        r.value    = v;
        return r;
    endfunction

    // bursts of requests separated by random gaps, some long enough to span a scan
    task automatic pace_sender();
        int gap;
        int roll;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            roll = $urandom_range(99);
            if (roll < 30)
                gap = 0;
            else if (roll < 80)
                gap = $urandom_range(1, 4);
            else
                gap = $urandom_range(5, DEPTH + 4);
            burst_left = ($urandom_range(9) == 0) ? 40 : $urandom_range(1, 16);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    // called at a falling edge; returns at a falling edge
    task automatic send_request(input req_t r);
        start <= 1'b1;
        req   <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        expected_rsp.push_back(apply_request(r));
        pace_sender();
    endtask

    task automatic test_empty_list();
        send_request(make_req(KIND_CLEAR, 0, 32'd0));
        send_request(make_req(KIND_DELETE, 0, 32'd0));
        send_request(make_req(KIND_READ, 0, 32'd0));
        send_request(make_req(KIND_SEARCH, 0, 32'd5));
        send_request(make_req(KIND_SEARCH, 0, 32'd0));
        send_request(make_req(KIND_INSERT, 1, 32'd9));
        send_request(make_req(KIND_UNUSED_A, 127, 32'hffff_ffff));
        send_request(make_req(KIND_UNUSED_B, 0, 32'd0));
    endtask

    task automatic test_edit_ops();
        send_request(make_req(KIND_APPEND, 0, 32'h8000_0000));
        send_request(make_req(KIND_APPEND, 127, 32'h7fff_ffff));
        send_request(make_req(KIND_APPEND, 0, 32'd0));
        send_request(make_req(KIND_APPEND, 0, 32'hffff_ffff));
        send_request(make_req(KIND_INSERT, 0, 32'd7));
        send_request(make_req(KIND_INSERT, 5, 32'd7));
        send_request(make_req(KIND_INSERT, 2, 32'h5555_5555));
        send_request(make_req(KIND_INSERT, 8, 32'd1));
        send_request(make_req(KIND_INSERT, 127, 32'd1));
        send_request(make_req(KIND_UNUSED_B, 3, 32'd7));
        send_request(make_req(KIND_READ, 0, 32'd0));
        send_request(make_req(KIND_READ, 6, 32'd0));
        send_request(make_req(KIND_READ, 7, 32'd0));
        send_request(make_req(KIND_SEARCH, 0, 32'd7));
        send_request(make_req(KIND_SEARCH, 0, 32'hffff_ffff));
        send_request(make_req(KIND_SEARCH, 0, 32'h8000_0000));
        send_request(make_req(KIND_SEARCH, 0, 32'h7fff_fffe));
        send_request(make_req(KIND_DELETE, 0, 32'd0));
        send_request(make_req(KIND_DELETE, 5, 32'd0));
        send_request(make_req(KIND_DELETE, 2, 32'd0));
        send_request(make_req(KIND_DELETE, 4, 32'd0));
        send_request(make_req(KIND_READ, 127, 32'd0));
        send_request(make_req(KIND_SEARCH, 0, 32'd7));
    endtask

    task automatic test_full_array();
        send_request(make_req(KIND_CLEAR, 0, 32'd0));
        for (int i = 0; i < DEPTH; i++)
            send_request(make_req(KIND_APPEND, 0, (i * 32'h0101_0101) ^ 32'ha5a5_0000));
        send_request(make_req(KIND_APPEND, 0, 32'd1));
        send_request(make_req(KIND_INSERT, DEPTH, 32'd1));
        send_request(make_req(KIND_INSERT, 0, 32'd1));
        send_request(make_req(KIND_INSERT, DEPTH + 1, 32'd1));
        send_request(make_req(KIND_INSERT, 127, 32'd1));
        send_request(make_req(KIND_SEARCH, 0, ((DEPTH - 1) * 32'h0101_0101) ^ 32'ha5a5_0000));
        send_request(make_req(KIND_READ, DEPTH - 1, 32'd0));
        send_request(make_req(KIND_READ, DEPTH, 32'd0));
        send_request(make_req(KIND_DELETE, DEPTH, 32'd0));
        send_request(make_req(KIND_DELETE, DEPTH - 1, 32'd0));
        send_request(make_req(KIND_INSERT, DEPTH - 1, 32'h8000_0000));
        send_request(make_req(KIND_SEARCH, 0, 32'h8000_0000));
        send_request(make_req(KIND_DELETE, 0, 32'd0));
        send_request(make_req(KIND_CLEAR, 0, 32'd0));
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(3);
        if (roll == 0)
            return $urandom_range(4) - 2;
        else if (roll == 1 && shadow_len > 0)
            return shadow_row[$urandom_range(shadow_len - 1)];
        else
            return $urandom;
    endfunction

    task automatic test_random_mix(input int target);
        int                  issued;
        int                  roll;
        int                  p;
        bit                  growing;
        logic [KIND_W-1:0]   k;
        logic [DATA_W-1:0]   v;
        issued  = 0;
        growing = 1'b1;
        while (issued < target)
        begin
            if ($urandom_range(99) < 2)
                growing = !growing;
            roll = $urandom_range(99);
            p    = (shadow_len == 0) ? 0 : $urandom_range(shadow_len - 1);
            v    = pick_value();
            if (roll < 6)
            begin
                k = KIND_W'($urandom_range(7));
                p = $urandom_range(127);
                v = $urandom;
            end
            else if (roll < 7)
                k = KIND_CLEAR;
            else if (roll < 13)
            begin
                case ($urandom_range(2))
                    0:       k = KIND_INSERT;
                    1:       k = KIND_DELETE;
                    default: k = KIND_READ;
                endcase
                p = $urandom_range((k == KIND_INSERT) ? shadow_len + 1 : shadow_len, 127);
            end
            else if (roll < (growing ? 48 : 22))
                k = KIND_APPEND;
            else if (roll < (growing ? 74 : 38))
            begin
                k = KIND_INSERT;
                p = $urandom_range(shadow_len);
            end
            else if (roll < (growing ? 78 : 72))
                k = KIND_DELETE;
            else if (roll < 89)
            begin
                k = KIND_SEARCH;
                if (shadow_len > 0 && $urandom_range(1))
                    v = shadow_row[$urandom_range(shadow_len - 1)];
            end
            else
                k = KIND_READ;
            if (k != KIND_UNUSED_A && k != KIND_UNUSED_B)
                issued++;
            send_request(make_req(k, p, v));
        end
    endtask

    task automatic drain_responses();
        start <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        req        = '0;
        shadow_len = 0;
        burst_left = 1;
        foreach (shadow_row[i])
            shadow_row[i] = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_list();
        test_edit_ops();
        test_full_array();
        test_random_mix(480);
        drain_responses();

        if (mismatches == 0)
            $display("PASS ordered_array_insert_delete_search");
        else
            $display("FAIL ordered_array_insert_delete_search");
        $finish;
    end

endmodule
